// ===== src/tri3d_pkg.sv =====
// Shared widths and types for the 3D triangle area pipeline.
package tri3d_pkg;

  localparam int COORD_BITS    = 16;
  localparam int NUM_FIELDS    = 9;
  localparam int OUT_BITS      = 34;

  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int MINOR_BITS    = PROD_BITS + 1;
  localparam int LO_BITS       = (MINOR_BITS + 1) / 2;
  localparam int HI_BITS       = MINOR_BITS - LO_BITS;
  localparam int SUM_BITS      = 2 * MINOR_BITS;
  localparam int ROOT_BITS     = MINOR_BITS;
  localparam int REM_BITS      = ROOT_BITS + 2;

  localparam int IN_DATA_BITS  = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [MINOR_BITS-1:0] minor_t;
  typedef logic [MINOR_BITS-1:0]        mag_t;
  typedef logic [SUM_BITS-1:0]          sum_t;
  typedef logic [ROOT_BITS-1:0]         root_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

endpackage

// ===== src/triangle_area_3d_unit.sv =====
// Top level: twice the area of a 3D triangle, streamed one triangle per cycle while the output buffer has room.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z
//  out_    | out | out_tvalid/tready  | out_tdata: twice_area (34 b), zero padded
//
//  One transaction per cycle sustained while the output buffer is not full.
//  Each transaction passes the cross stages, the squares and sum stages, the
//  square root stages (one root bit per stage) and the output register.
//  Reset (rst_n low, synchronous) clears every stage valid bit and the
//  output buffer; payload registers are not reset.
//  A two-entry output buffer takes results while out_tready is low; the
//  pipeline holds (no transaction lost or repeated) only once both are full.
module triangle_area_3d_unit
  import tri3d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // fields from bit 0: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // fields from bit 0: twice_area, then zero fill
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  localparam logic [1:0] BUF_FULL = 2'd2;

  vec_t   a_v, b_v, c_v;
  logic   pipe_en;
  logic   cross_vld, sq_vld, root_vld;
  minor_t m1, m2, m3;
  sum_t   sum;
  root_t  root;

  logic [1:0]          cnt_r, cnt_nxt;
  logic [OUT_BITS-1:0] head_r, head_nxt;
  logic [OUT_BITS-1:0] tail_r, tail_nxt;
  logic                push, pop;
  logic [OUT_BITS-1:0] res;

  // unpack the vertex fields, lowest field first
  always_comb begin
    a_v.x = in_tdata[0*COORD_BITS +: COORD_BITS];
    a_v.y = in_tdata[1*COORD_BITS +: COORD_BITS];
    a_v.z = in_tdata[2*COORD_BITS +: COORD_BITS];
    b_v.x = in_tdata[3*COORD_BITS +: COORD_BITS];
    b_v.y = in_tdata[4*COORD_BITS +: COORD_BITS];
    b_v.z = in_tdata[5*COORD_BITS +: COORD_BITS];
    c_v.x = in_tdata[6*COORD_BITS +: COORD_BITS];
    c_v.y = in_tdata[7*COORD_BITS +: COORD_BITS];
    c_v.z = in_tdata[8*COORD_BITS +: COORD_BITS];
  end

  // advance the whole pipeline unless the output buffer is full
  assign pipe_en   = (cnt_r != BUF_FULL);
  assign in_tready = pipe_en;

  tri3d_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (in_tvalid),
    .a       (a_v),
    .b       (b_v),
    .c       (c_v),
    .out_vld (cross_vld),
    .m1      (m1),
    .m2      (m2),
    .m3      (m3)
  );

  tri3d_sqsum u_sqsum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (cross_vld),
    .m1      (m1),
    .m2      (m2),
    .m3      (m3),
    .out_vld (sq_vld),
    .sum     (sum)
  );

  tri3d_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (sq_vld),
    .rad     (sum),
    .out_vld (root_vld),
    .root    (root)
  );

  // keep the low result bits; zero extend for narrow coordinates
  assign res  = OUT_BITS'(root);
  assign push = pipe_en & root_vld;
  assign pop  = out_tvalid & out_tready;

  // two-entry output buffer: head drives the port, tail catches a stalled result
  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (push && !pop) begin
      if (cnt_r == 2'd0) begin
        head_nxt = res;
      end else begin
        tail_nxt = res;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (push && pop) begin
      if (cnt_r == 2'd1) begin
        head_nxt = res;
      end else begin
        head_nxt = tail_r;
        tail_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = OUT_DATA_BITS'(head_r);

endmodule

// ===== src/tri3d_cross.sv =====
// Edge vectors, partial products and cross product minors, three stages.
module tri3d_cross
  import tri3d_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  vec_t   a,
  input  vec_t   b,
  input  vec_t   c,
  output logic   out_vld,
  output minor_t m1,
  output minor_t m2,
  output minor_t m3
);

  logic [2:0] vld_r;
  diff_t ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  prod_t p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  minor_t m1_r, m2_r, m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edges from the first vertex
      ux_r <= DIFF_BITS'(b.x) - DIFF_BITS'(a.x);
      uy_r <= DIFF_BITS'(b.y) - DIFF_BITS'(a.y);
      uz_r <= DIFF_BITS'(b.z) - DIFF_BITS'(a.z);
      vx_r <= DIFF_BITS'(c.x) - DIFF_BITS'(a.x);
      vy_r <= DIFF_BITS'(c.y) - DIFF_BITS'(a.y);
      vz_r <= DIFF_BITS'(c.z) - DIFF_BITS'(a.z);
      p1_r <= PROD_BITS'(uy_r) * PROD_BITS'(vz_r);
      p2_r <= PROD_BITS'(uz_r) * PROD_BITS'(vy_r);
      p3_r <= PROD_BITS'(vx_r) * PROD_BITS'(uz_r);
      p4_r <= PROD_BITS'(ux_r) * PROD_BITS'(vz_r);
      p5_r <= PROD_BITS'(ux_r) * PROD_BITS'(vy_r);
      p6_r <= PROD_BITS'(vx_r) * PROD_BITS'(uy_r);
      m1_r <= MINOR_BITS'(p1_r) - MINOR_BITS'(p2_r);
      m2_r <= MINOR_BITS'(p3_r) - MINOR_BITS'(p4_r);
      m3_r <= MINOR_BITS'(p5_r) - MINOR_BITS'(p6_r);
    end
  end

  assign out_vld = vld_r[2];
  assign m1      = m1_r;
  assign m2      = m2_r;
  assign m3      = m3_r;

endmodule

// ===== src/tri3d_sqsum.sv =====
// Squares of the three minors from split partial products, then their sum.
module tri3d_sqsum
  import tri3d_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  minor_t m1,
  input  minor_t m2,
  input  minor_t m3,
  output logic   out_vld,
  output sum_t   sum
);

  logic [3:0] vld_r;
  minor_t m_in [3];
  logic [HI_BITS-1:0]           hi_r [3];
  logic [LO_BITS-1:0]           lo_r [3];
  logic [2*HI_BITS-1:0]         hh_r [3];
  logic [HI_BITS+LO_BITS-1:0]   hl_r [3];
  logic [2*LO_BITS-1:0]         ll_r [3];
  sum_t sq_r [3];
  sum_t sum_r;
  mag_t mag [3];

  assign m_in[0] = m1;
  assign m_in[1] = m2;
  assign m_in[2] = m3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = m_in[i][MINOR_BITS-1] ? mag_t'(-m_in[i]) : mag_t'(m_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hi_r[i] <= mag[i][MINOR_BITS-1:LO_BITS];
        lo_r[i] <= mag[i][LO_BITS-1:0];
        hh_r[i] <= (2*HI_BITS)'(hi_r[i]) * (2*HI_BITS)'(hi_r[i]);
        hl_r[i] <= (HI_BITS+LO_BITS)'(hi_r[i]) * (HI_BITS+LO_BITS)'(lo_r[i]);
        ll_r[i] <= (2*LO_BITS)'(lo_r[i]) * (2*LO_BITS)'(lo_r[i]);
        // (h*2^L + l)^2 = h^2*2^2L + 2*h*l*2^L + l^2
        sq_r[i] <= (SUM_BITS'(hh_r[i]) << (2 * LO_BITS))
                 + (SUM_BITS'(hl_r[i]) << (LO_BITS + 1))
                 + SUM_BITS'(ll_r[i]);
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign out_vld = vld_r[3];
  assign sum     = sum_r;

endmodule

// ===== src/tri3d_isqrt.sv =====
// Pipelined restoring integer square root, one root bit per stage.
module tri3d_isqrt
  import tri3d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  sum_t  rad,
  output logic  out_vld,
  output root_t root
);

  logic [ROOT_BITS-1:0] vld_r;
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS-1];
  root_t                root_r [ROOT_BITS];
  sum_t                 rad_r  [ROOT_BITS-1];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [REM_BITS-1:0] rem_in;
    root_t               root_in;
    sum_t                rad_in;
    logic                vld_in;
    logic [REM_BITS-1:0] r_try;
    logic [REM_BITS-1:0] trial;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign r_try = {rem_in[REM_BITS-3:0], rad_in[SUM_BITS-1:SUM_BITS-2]};
    assign trial = {root_in, 2'b01};
    assign take  = (r_try >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[ROOT_BITS-2:0], take};
      end
    end

    if (k < ROOT_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (r_try - trial) : r_try;
          rad_r[k] <= rad_in << 2;
        end
      end
    end
  end

  assign out_vld = vld_r[ROOT_BITS-1];
  assign root    = root_r[ROOT_BITS-1];

endmodule
